/* src/qwa_pkg.sv */
`default_nettype none

package qwa_pkg;

	localparam int CMD_W = 2;
	localparam int SLOT_W = 4;
	localparam int RANK_W = 16;
	localparam int RUN_W = 24;
	localparam int CNT_W = 5;

	// s_tdata: slot, rank, run_count from bit 0 up
	localparam int SLOT_LSB = 0;
	localparam int RANK_LSB = SLOT_LSB + SLOT_W;
	localparam int RUN_LSB = RANK_LSB + RANK_W;
	localparam int S_TDATA_W = 48;

	// m_tdata: assigned_rank, free_count from bit 0 up
	localparam int FREE_LSB = RANK_W;
	localparam int M_TDATA_W = 24;

	// m_tuser bits
	localparam int GRANT_BIT = 0;
	localparam int MISS_BIT = 1;
	localparam int M_TUSER_W = 2;

	localparam int DIV_CNT_W = 5;

	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD    = 2'd0,
		CMD_START   = 2'd1,
		CMD_REQUEST = 2'd2,
		CMD_RELEASE = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_READ,
		ST_DIV,
		ST_FILL,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic             done;
		logic [RUN_W-1:0] quot;
		logic [CNT_W-1:0] rem;
	} div_res_t;

endpackage

`default_nettype wire

/* src/qwa_ram.sv */
`default_nettype none

module qwa_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

/* src/qwa_scan.sv */
`default_nettype none

module qwa_scan #(
	parameter int N = 16,
	localparam int AW = (N > 1) ? $clog2(N) : 1
) (
	input  logic [N-1:0]  req,
	output logic          hit,
	output logic [AW-1:0] idx
);

	// lowest set bit wins
	always_comb begin
		hit = |req;
		idx = '0;
		for (int i = N - 1; i >= 0; i--) begin
			if (req[i]) begin
				idx = AW'(i);
			end
		end
	end

endmodule

`default_nettype wire

/* src/qwa_div.sv */
`default_nettype none

module qwa_div (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [qwa_pkg::RUN_W-1:0] dividend,
	input  logic [qwa_pkg::CNT_W-1:0] divisor,
	output qwa_pkg::div_res_t       res
);

	import qwa_pkg::*;

	logic                 run_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0]     div_q;
	logic [CNT_W-1:0]     rem_q;
	logic [RUN_W-1:0]     quo_q;
	logic [CNT_W:0]       trial;
	logic                 fits;

	// restoring division, one quotient bit a cycle
	assign trial = {rem_q, quo_q[RUN_W-1]};
	assign fits = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= DIV_CNT_W'(RUN_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= divisor;
			rem_q <= '0;
			quo_q <= dividend;
		end else if (run_q) begin
			rem_q <= fits ? CNT_W'(trial - {1'b0, div_q}) : CNT_W'(trial);
			quo_q <= {quo_q[RUN_W-2:0], fits};
		end
	end

	assign res.done = done_q;
	assign res.quot = quo_q;
	assign res.rem = rem_q;

endmodule

`default_nettype wire

/* src/quota_worker_assigner.sv */
// Worker assigner with per-slot quotas. Load writes a rank into a slot, start
// clears all busy marks, sets the free count and, given a nonzero run count,
// shares the runs out over the slots in use; request grants the lowest idle
// slot with quota left, release lowers the quota of the lowest slot holding
// the rank and frees it. One item is worked at a time; a finished result
// sits in the output register while the next item is taken. Load, start
// without runs, a missed request and an unknown release pass the exec and
// done states before the next ready; a grant or a matched release also
// passes a read state, for the registered read of the rank or quota
// memory. Start with runs goes through the 24 steps of the bit-serial divider,
// then a sweep that writes one quota memory entry per cycle. No clearing
// pass runs after reset: per-slot flags mark empty quotas.
`default_nettype none

module quota_worker_assigner #(
	parameter int MAX_WORKERS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [qwa_pkg::CNT_W-1:0]     cfg_wr_data,   // worker_count
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [qwa_pkg::S_TDATA_W-1:0] s_tdata,       // slot, rank, run_count
	input  logic [qwa_pkg::CMD_W-1:0]     s_tuser,       // command
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [qwa_pkg::M_TDATA_W-1:0] m_tdata,       // assigned_rank, free_count
	output logic [qwa_pkg::M_TUSER_W-1:0] m_tuser        // granted, not_found
);

	import qwa_pkg::*;

	localparam int AW = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
	localparam int CW = (AW > CNT_W) ? AW : CNT_W;
	localparam logic [CNT_W-1:0] MAX_CNT =
		(MAX_WORKERS > 31) ? CNT_W'(31) : CNT_W'(MAX_WORKERS);
	localparam logic [AW-1:0] LAST_IDX = AW'(MAX_WORKERS - 1);

	state_t st_q, st_d;

	logic [CNT_W-1:0]  wc_q;
	cmd_t              cmd_q;
	logic [SLOT_W-1:0] slot_q;
	logic [RANK_W-1:0] rank_q;
	logic [RUN_W-1:0]  runs_q;

	logic [MAX_WORKERS-1:0] busy_q;
	logic [MAX_WORKERS-1:0] nz_q;
	logic [RANK_W-1:0]      rank_f_q [MAX_WORKERS];
	logic [CNT_W-1:0]       idle_q;
	logic [AW-1:0]          idx_q;
	logic [AW-1:0]          fill_idx_q;

	logic              res_granted_q;
	logic              res_miss_q;
	logic [RANK_W-1:0] res_rank_q;

	logic              m_tvalid_q;
	logic              m_granted_q;
	logic              m_miss_q;
	logic [RANK_W-1:0] m_rank_q;
	logic [CNT_W-1:0]  m_free_q;

	logic [CNT_W-1:0]       n;
	logic [MAX_WORKERS-1:0] req_cand;
	logic [MAX_WORKERS-1:0] rel_cand;
	logic                   req_hit;
	logic                   rel_hit;
	logic [AW-1:0]          req_idx;
	logic [AW-1:0]          rel_idx;
	logic                   slot_ok;
	logic                   runs_go;
	logic                   out_free;
	logic                   fill_last;

	logic do_load;
	logic do_start;
	logic div_start;
	logic do_grant;
	logic do_release;
	logic do_miss;
	logic rd_release;
	logic quota_we;
	logic out_load;

	logic [RANK_W-1:0] rank_rd;
	logic [RUN_W-1:0]  quota_rd;
	logic [RUN_W-1:0]  fill_val;
	logic [AW-1:0]     quota_waddr;
	logic [RUN_W-1:0]  quota_wdata;
	div_res_t          div_res;

	assign n = (wc_q > MAX_CNT) ? MAX_CNT : wc_q;
	assign slot_ok = 32'(slot_q) < MAX_WORKERS;
	assign runs_go = (runs_q != '0) && (n != '0);
	assign out_free = !m_tvalid_q || m_tready;
	assign fill_last = fill_idx_q == LAST_IDX;

	always_comb begin
		for (int i = 0; i < MAX_WORKERS; i++) begin
			req_cand[i] = (CW'(i) < CW'(n)) && !busy_q[i] && nz_q[i];
			rel_cand[i] = (CW'(i) < CW'(n)) && (rank_f_q[i] == rank_q);
		end
	end

	qwa_scan #(.N(MAX_WORKERS)) u_req_scan (
		.req (req_cand),
		.hit (req_hit),
		.idx (req_idx)
	);

	qwa_scan #(.N(MAX_WORKERS)) u_rel_scan (
		.req (rel_cand),
		.hit (rel_hit),
		.idx (rel_idx)
	);

	qwa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (runs_q),
		.divisor  (n),
		.res      (div_res)
	);

	// runs / n to every slot in use, one more for the lowest remainder slots
	always_comb begin
		fill_val = '0;
		if (CW'(fill_idx_q) < CW'(n)) begin
			fill_val = div_res.quot + RUN_W'(CW'(fill_idx_q) < CW'(div_res.rem));
		end
	end

	assign quota_waddr = (st_q == ST_FILL) ? fill_idx_q : idx_q;
	assign quota_wdata = (st_q == ST_FILL) ? fill_val : quota_rd - 1'b1;

	qwa_ram #(.WIDTH(RANK_W), .DEPTH(MAX_WORKERS)) u_rank_ram (
		.clk   (clk),
		.we    (do_load),
		.waddr (AW'(slot_q)),
		.wdata (rank_q),
		.raddr (req_idx),
		.rdata (rank_rd)
	);

	qwa_ram #(.WIDTH(RUN_W), .DEPTH(MAX_WORKERS)) u_quota_ram (
		.clk   (clk),
		.we    (quota_we),
		.waddr (quota_waddr),
		.wdata (quota_wdata),
		.raddr (rel_idx),
		.rdata (quota_rd)
	);

	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE: begin
				if (s_tvalid) st_d = ST_EXEC;
			end
			ST_EXEC: begin
				case (cmd_q)
					CMD_START:   st_d = runs_go ? ST_DIV : ST_DONE;
					CMD_REQUEST: st_d = req_hit ? ST_READ : ST_DONE;
					CMD_RELEASE: st_d = rel_hit ? ST_READ : ST_DONE;
					default:     st_d = ST_DONE;
				endcase
			end
			ST_READ: st_d = ST_DONE;
			ST_DIV: begin
				if (div_res.done) st_d = ST_FILL;
			end
			ST_FILL: begin
				if (fill_last) st_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) st_d = ST_IDLE;
			end
			default: st_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = st_q == ST_IDLE;
		do_load = (st_q == ST_EXEC) && (cmd_q == CMD_LOAD) && slot_ok;
		do_start = (st_q == ST_EXEC) && (cmd_q == CMD_START);
		div_start = do_start && runs_go;
		do_grant = (st_q == ST_EXEC) && (cmd_q == CMD_REQUEST) && req_hit;
		do_release = (st_q == ST_EXEC) && (cmd_q == CMD_RELEASE) && rel_hit;
		do_miss = (st_q == ST_EXEC) && (cmd_q == CMD_RELEASE) && !rel_hit;
		rd_release = (st_q == ST_READ) && (cmd_q == CMD_RELEASE);
		quota_we = (st_q == ST_FILL) || (rd_release && nz_q[idx_q]);
		out_load = (st_q == ST_DONE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			wc_q <= CNT_W'(1);
			busy_q <= '0;
			nz_q <= '0;
			idle_q <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (cfg_wr_en) begin
				wc_q <= cfg_wr_data;
			end
			if (do_start) begin
				busy_q <= '0;
				idle_q <= n;
			end
			if (do_grant) begin
				busy_q[req_idx] <= 1'b1;
				if (idle_q != '0) idle_q <= idle_q - 1'b1;
			end
			if (do_release && busy_q[rel_idx]) begin
				busy_q[rel_idx] <= 1'b0;
				idle_q <= idle_q + 1'b1;
			end
			if (st_q == ST_FILL) begin
				nz_q[fill_idx_q] <= fill_val != '0;
			end
			// a quota of one drops to empty; an empty one stays empty
			if (rd_release && quota_rd == RUN_W'(1)) begin
				nz_q[idx_q] <= 1'b0;
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			cmd_q <= cmd_t'(s_tuser);
			slot_q <= s_tdata[SLOT_LSB +: SLOT_W];
			rank_q <= s_tdata[RANK_LSB +: RANK_W];
			runs_q <= s_tdata[RUN_LSB +: RUN_W];
		end
		if (do_load) begin
			rank_f_q[AW'(slot_q)] <= rank_q;
		end
		if (st_q == ST_EXEC) begin
			res_granted_q <= do_grant;
			res_miss_q <= do_miss;
			res_rank_q <= '0;
			idx_q <= (cmd_q == CMD_REQUEST) ? req_idx : rel_idx;
		end
		if ((st_q == ST_READ) && (cmd_q == CMD_REQUEST)) begin
			res_rank_q <= rank_rd;
		end
		if (div_start) begin
			fill_idx_q <= '0;
		end else if (st_q == ST_FILL) begin
			fill_idx_q <= fill_idx_q + 1'b1;
		end
		if (out_load) begin
			m_granted_q <= res_granted_q;
			m_miss_q <= res_miss_q;
			m_rank_q <= res_rank_q;
			m_free_q <= idle_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = {{(M_TDATA_W - RANK_W - CNT_W){1'b0}}, m_free_q, m_rank_q};
	assign m_tuser = {m_miss_q, m_granted_q};

endmodule

`default_nettype wire

/* src/qwa_checker.sv */
`default_nettype none

module qwa_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [qwa_pkg::M_TDATA_W-1:0] m_tdata,
	input logic [qwa_pkg::M_TUSER_W-1:0] m_tuser
);

	import qwa_pkg::*;

	logic       in_xfer;
	logic       out_xfer;
	logic [1:0] pend_q;

	assign in_xfer = s_tvalid && s_tready;
	assign out_xfer = m_tvalid && m_tready;

	// transactions taken in but not yet handed out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (in_xfer && !out_xfer) begin
			pend_q <= pend_q + 1'b1;
		end else if (out_xfer && !in_xfer) begin
			pend_q <= pend_q - 1'b1;
		end
	end

	a_grant_or_miss: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[GRANT_BIT] && m_tuser[MISS_BIT]))
		else $error("grant and miss flagged together");

	a_rank_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[GRANT_BIT]) |-> (m_tdata[RANK_W-1:0] == '0))
		else $error("rank shown without a grant");

	a_result_has_source: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (pend_q != 2'd0))
		else $error("result without an accepted transaction");

	a_at_most_two: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3)
		else $error("more than two transactions in flight");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
		else $error("stalled result changed");

endmodule

bind quota_worker_assigner qwa_checker u_qwa_checker (.*);

`default_nettype wire
